/* hw/rtl/aes256_block_cipher_macros.svh */
// Assertion macros shared by the AES-256 RTL
`ifndef AES256_BLOCK_CIPHER_MACROS_SVH
`define AES256_BLOCK_CIPHER_MACROS_SVH

// Check that an antecedent implies a consequent on the next clock
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the same clock
`define AES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/aes_pkg.sv */
// Package with types, constants and round functions for the AES-256 core
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 14;

  typedef struct packed {
    logic        func;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  localparam logic [7:0] Poly = 8'h1b;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? Poly : 8'h00);
  endfunction

  // Byte n of a 128-bit state sits at bits [127-8n -: 8]
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
    get_byte = s[127 - 8*n -: 8];
  endfunction

  // Forward SubBytes and ShiftRows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127 - 8*(r + 4*c) -: 8] = FWD_SBOX[get_byte(s, r + 4*((c + r) & 3))];
      end
    end
    sub_shift = o;
  endfunction

  // Inverse ShiftRows and SubBytes
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127 - 8*(r + 4*((c + r) & 3)) -: 8] = INV_SBOX[get_byte(s, r + 4*c)];
      end
    end
    inv_shift_sub = o;
  endfunction

  // Forward MixColumns
  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      o[127 - 32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119 - 32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111 - 32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103 - 32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_cols = o;
  endfunction

  // Inverse MixColumns: premultiply by {05,00,04,00} then forward mix
  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [127:0] p;
    logic [7:0] a0, a1, a2, a3, u, v;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      p[127 - 32*c -: 8] = a0 ^ u;
      p[119 - 32*c -: 8] = a1 ^ v;
      p[111 - 32*c -: 8] = a2 ^ u;
      p[103 - 32*c -: 8] = a3 ^ v;
    end
    inv_mix_cols = mix_cols(p);
  endfunction

  // Apply S-box to each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Advance a 256-bit key window by one schedule step (two round keys)
  function automatic logic [255:0] key_fwd(input logic [255:0] k, input logic [7:0] rcon);
    logic [31:0] w [8];
    logic [31:0] n [8];
    logic [31:0] t;
    for (int i = 0; i < 8; i++) w[i] = k[255 - 32*i -: 32];
    t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon, 24'h0};
    n[0] = w[0] ^ t;
    n[1] = w[1] ^ n[0];
    n[2] = w[2] ^ n[1];
    n[3] = w[3] ^ n[2];
    n[4] = w[4] ^ sub_word(n[3]);
    n[5] = w[5] ^ n[4];
    n[6] = w[6] ^ n[5];
    n[7] = w[7] ^ n[6];
    key_fwd = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
  endfunction

  // Step a 256-bit key window back by one schedule step
  function automatic logic [255:0] key_bwd(input logic [255:0] k, input logic [7:0] rcon);
    logic [31:0] n [8];
    logic [31:0] w [8];
    for (int i = 0; i < 8; i++) n[i] = k[255 - 32*i -: 32];
    w[7] = n[7] ^ n[6];
    w[6] = n[6] ^ n[5];
    w[5] = n[5] ^ n[4];
    w[4] = n[4] ^ sub_word(n[3]);
    w[3] = n[3] ^ n[2];
    w[2] = n[2] ^ n[1];
    w[1] = n[1] ^ n[0];
    w[0] = n[0] ^ sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon, 24'h0};
    key_bwd = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  endfunction

  // Inverse of xtime for the round constant sequence used here
  function automatic logic [7:0] xtime_inv(input logic [7:0] x);
    xtime_inv = x[0] ? ({1'b1, x[7:1]} ^ 8'h8d) : {1'b0, x[7:1]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/aes256_block_cipher.sv */
// AES-256 round-iterative block cipher with APB key registers
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+----------------
//  command  | in        | start, busy      | cmd (aes_in_t)
//  result   | out       | done strobe      | result (aes_out_t)
//  config   | in        | APB psel/penable | 64-bit key words
//
// Encrypt: after the accepting edge the block makes one pass per cycle
// through one shared round unit (initial key add + 14 rounds), then done rises;
// the next transfer can be taken at the edge that ends the done cycle.
// Decrypt first runs the key schedule forward to its last window, then makes
// the same round passes with the round keys in reverse order before done.
// Reset is synchronous and clears the key and the sequencer.
// done is a single-cycle strobe; the receiver cannot stall it.
`default_nettype none
module aes256_block_cipher
  import aes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire aes_in_t     cmd,
  output logic             busy,
  output logic             done,
  output aes_out_t         result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
`include "aes256_block_cipher_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEXP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  logic [63:0]  key_reg [4];
  logic [1:0]   state;
  logic [3:0]   round;
  logic         dec;
  logic [127:0] blk;
  logic [255:0] kwin;
  logic [7:0]   rcon;
  logic [2:0]   kcnt;
  logic [127:0] rk;
  logic [127:0] enc_next;
  logic [127:0] dec_next;
  logic         wr_en;

  // APB writes on access phase; reads mux the key registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_KEY0: key_reg[0] <= pwdata;
        REG_KEY1: key_reg[1] <= pwdata;
        REG_KEY2: key_reg[2] <= pwdata;
        REG_KEY3: key_reg[3] <= pwdata;
        default: ;
      endcase
    end
  end
  assign prdata = key_reg[paddr[4:3]];

  // Pick the round key: even rounds take the upper half of the window
  always_comb begin
    rk = round[0] ? kwin[127:0] : kwin[255:128];
  end

  // Shared round datapath
  always_comb begin
    enc_next = (round == 4'd14) ? sub_shift(blk) ^ rk : mix_cols(sub_shift(blk)) ^ rk;
    dec_next = (round == 4'd14) ? inv_shift_sub(blk) ^ rk
                                : inv_mix_cols(inv_shift_sub(blk) ^ rk);
  end

  // Sequencer: load, optional key run-forward, then round passes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      round <= '0;
      kcnt  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            dec  <= cmd.func;
            blk  <= {cmd.block_hi, cmd.block_lo};
            kwin <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
            rcon <= 8'h01;
            kcnt <= '0;
            round <= '0;
            state <= cmd.func ? ST_KEXP : ST_RUN;
          end
        end
        ST_KEXP: begin
          // run forward to the window of round keys 14 and 15
          kwin <= key_fwd(kwin, rcon);
          rcon <= xtime(rcon);
          kcnt <= kcnt + 3'd1;
          if (kcnt == 3'd6) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (round == 4'd0) begin
            blk <= blk ^ rk;
          end else if (dec) begin
            blk <= dec_next;
          end else begin
            blk <= enc_next;
          end
          // step the key window once both of its round keys are used
          if (dec ? (!round[0] && round != 4'd14) : round[0]) begin
            if (dec) begin
              kwin <= key_bwd(kwin, xtime_inv(rcon));
              rcon <= xtime_inv(rcon);
            end else begin
              kwin <= key_fwd(kwin, rcon);
              rcon <= xtime(rcon);
            end
          end
          round <= round + 4'd1;
          if (round == 4'(NumRounds)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state != ST_IDLE);
  assign result = blk;

  `AES_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted item did not set busy")
  `AES_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "done without returning idle")
  `AES_ASSERT_SAME(a_done_round, clk, rst, done, round == 4'd15, "done at wrong round count")

endmodule
`default_nettype wire
